// ===== rtl/core/timed_valve_pulse_counter_defines.svh =====
`ifndef TIMED_VALVE_PULSE_COUNTER_DEFINES_SVH
`define TIMED_VALVE_PULSE_COUNTER_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define TVPC_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("tvpc assertion failed");

// condition must hold in the cycle after the trigger
`define TVPC_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("tvpc assertion failed");

`endif

// ===== rtl/core/tvpc_pkg.sv =====
package tvpc_pkg;

   localparam int ButtonCount  = 4;
   localparam int CountWidth   = 32;
   localparam int TickWidth    = 25;
   localparam int SinceWidth   = 17;
   localparam int CycleWidth   = 4;
   localparam int SecondsWidth = 8;
   localparam int CfgWidth     = 16;
   localparam int CsrIdxWidth  = 3;

   localparam logic [CsrIdxWidth-1:0] RegDebounce     = 3'd0;
   localparam logic [CsrIdxWidth-1:0] RegTicksPerSec  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] RegPause        = 3'd2;
   localparam logic [CsrIdxWidth-1:0] RegSplitCycles  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] RegSeconds0     = 3'd4;
   localparam logic [CsrIdxWidth-1:0] RegSeconds1     = 3'd5;
   localparam logic [CsrIdxWidth-1:0] RegSeconds2     = 3'd6;
   localparam logic [CsrIdxWidth-1:0] RegSeconds3     = 3'd7;

   typedef enum logic [1:0] {
      PhIdle  = 2'd0,
      PhOpen  = 2'd1,
      PhPause = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CfgWidth-1:0]                         debounce_ticks;
      logic [CfgWidth-1:0]                         ticks_per_second;
      logic [CfgWidth-1:0]                         pause_ticks;
      logic [CycleWidth-1:0]                       split_cycles;
      logic [ButtonCount-1:0][SecondsWidth-1:0]    seconds;
   } cfg_type;

   typedef struct packed {
      logic                   pulse_edge;
      logic [ButtonCount-1:0] buttons;
   } req_type;

   typedef struct packed {
      logic                  valve_open;
      logic                  busy_res;
      logic                  in_pause;
      logic [CycleWidth-1:0] cycle_number;
      logic [CountWidth-1:0] pulse_total;
      logic                  run_done;
   } rsp_type;

endpackage

// ===== rtl/core/tvpc_req_if.sv =====
interface tvpc_req_if;
   logic                             valid;
   logic                             ready;
   logic                             pulse_edge;
   logic [tvpc_pkg::ButtonCount-1:0] buttons;

   modport source (output valid, pulse_edge, buttons, input ready);
   modport sink (input valid, pulse_edge, buttons, output ready);
endinterface

// ===== rtl/core/tvpc_rsp_if.sv =====
interface tvpc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            valve_open;
   logic                            busy_res;
   logic                            in_pause;
   logic [tvpc_pkg::CycleWidth-1:0] cycle_number;
   logic [tvpc_pkg::CountWidth-1:0] pulse_total;
   logic                            run_done;

   modport source (output valid, valve_open, busy_res, in_pause, cycle_number,
                   pulse_total, run_done, input ready);
   modport sink (input valid, valve_open, busy_res, in_pause, cycle_number,
                 pulse_total, run_done, output ready);
endinterface

// ===== rtl/core/tvpc_csr.sv =====
module tvpc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [tvpc_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [tvpc_pkg::CfgWidth-1:0]     csr_wdata,
   output tvpc_pkg::cfg_type                 cfg
);

   tvpc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= 16'd500;
         cfg_ff.ticks_per_second <= 16'd1000;
         cfg_ff.pause_ticks      <= 16'd2000;
         cfg_ff.split_cycles     <= 4'd10;
         cfg_ff.seconds[0]       <= 8'd1;
         cfg_ff.seconds[1]       <= 8'd3;
         cfg_ff.seconds[2]       <= 8'd10;
         cfg_ff.seconds[3]       <= 8'd100;
      end else if (csr_we) begin
         unique case (csr_index)
            tvpc_pkg::RegDebounce:    cfg_ff.debounce_ticks   <= csr_wdata;
            tvpc_pkg::RegTicksPerSec: cfg_ff.ticks_per_second <= csr_wdata;
            tvpc_pkg::RegPause:       cfg_ff.pause_ticks      <= csr_wdata;
            tvpc_pkg::RegSplitCycles: begin
               cfg_ff.split_cycles <= csr_wdata[tvpc_pkg::CycleWidth-1:0];
            end
            tvpc_pkg::RegSeconds0: cfg_ff.seconds[0] <= csr_wdata[7:0];
            tvpc_pkg::RegSeconds1: cfg_ff.seconds[1] <= csr_wdata[7:0];
            tvpc_pkg::RegSeconds2: cfg_ff.seconds[2] <= csr_wdata[7:0];
            tvpc_pkg::RegSeconds3: cfg_ff.seconds[3] <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/tvpc_core.sv =====
`include "timed_valve_pulse_counter_defines.svh"

module tvpc_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  tvpc_pkg::req_type  item,
   input  tvpc_pkg::cfg_type  cfg,
   output tvpc_pkg::rsp_type  res
);

   tvpc_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [tvpc_pkg::TickWidth-1:0]    pt_ff, pt_in, pt_cur, pt_inc, open_len;
   logic [tvpc_pkg::CycleWidth-1:0]   cd_ff, cd_in, cd_cur, cd_inc, cycle_lim;
   logic                              split_ff, split_in;
   logic [tvpc_pkg::SecondsWidth-1:0] sec_ff, sec_in;
   logic [tvpc_pkg::CountWidth-1:0]   pc_ff, pc_in;
   logic [tvpc_pkg::SinceWidth-1:0]   tsp_ff, tsp_in;
   logic [1:0]                        btn_sel;
   logic [23:0]                       product;
   logic                              start, cycle_end, finish;

   // lowest numbered pressed button wins
   always_comb begin
      priority if (item.buttons[0]) btn_sel = 2'd0;
      else if (item.buttons[1])     btn_sel = 2'd1;
      else if (item.buttons[2])     btn_sel = 2'd2;
      else                          btn_sel = 2'd3;
   end

   // idle: button check, debounce counter, run start
   always_comb begin
      start    = 1'b0;
      split_in = split_ff;
      sec_in   = sec_ff;
      tsp_in   = tsp_ff;
      if (phase_ff == tvpc_pkg::PhIdle) begin
         if (item.buttons != '0) begin
            if (tsp_ff > {1'b0, cfg.debounce_ticks}) begin
               start    = 1'b1;
               split_in = (btn_sel < 2'd2);
               sec_in   = cfg.seconds[btn_sel];
            end
            tsp_in = '0;
         end else if (tsp_ff != '1) begin
            tsp_in = tsp_ff + 1'b1;
         end
      end
   end

   assign phase_cur = start ? tvpc_pkg::PhOpen : phase_ff;
   assign pt_cur    = start ? '0 : pt_ff;
   assign cd_cur    = start ? '0 : cd_ff;
   assign pc_in     = (start ? '0 : pc_ff) + {{(tvpc_pkg::CountWidth-1){1'b0}}, item.pulse_edge};

   assign product   = sec_in * cfg.ticks_per_second;
   assign open_len  = {1'b0, product} + 1'b1;
   assign pt_inc    = pt_cur + 1'b1;
   assign cd_inc    = cd_cur + 1'b1;
   assign cycle_lim = (cfg.split_cycles == '0) ? 4'd1 : cfg.split_cycles;

   // open and pause timing
   always_comb begin
      phase_in  = phase_cur;
      pt_in     = pt_cur;
      cd_in     = cd_cur;
      cycle_end = 1'b0;
      finish    = 1'b0;
      unique case (phase_cur)
         tvpc_pkg::PhOpen: begin
            if (pt_inc >= open_len) begin
               pt_in = '0;
               if (!split_in) begin
                  finish = 1'b1;
               end else if (cfg.pause_ticks != '0) begin
                  phase_in = tvpc_pkg::PhPause;
               end else begin
                  cycle_end = 1'b1;
               end
            end else begin
               pt_in = pt_inc;
            end
         end
         tvpc_pkg::PhPause: begin
            if (pt_inc >= {9'd0, cfg.pause_ticks}) begin
               pt_in     = '0;
               cycle_end = 1'b1;
            end else begin
               pt_in = pt_inc;
            end
         end
         default: ;
      endcase
      if (cycle_end) begin
         cd_in = cd_inc;
         if (cd_inc >= cycle_lim) begin
            finish = 1'b1;
         end else begin
            phase_in = tvpc_pkg::PhOpen;
         end
      end
      if (finish) begin
         phase_in = tvpc_pkg::PhIdle;
         pt_in    = '0;
         cd_in    = '0;
      end
   end

   always_comb begin
      res.valve_open   = (phase_cur == tvpc_pkg::PhOpen);
      res.busy_res     = (phase_cur != tvpc_pkg::PhIdle);
      res.in_pause     = (phase_cur == tvpc_pkg::PhPause);
      res.cycle_number = (res.busy_res && split_in) ? cd_inc : '0;
      res.pulse_total  = pc_in;
      res.run_done     = finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tvpc_pkg::PhIdle;
         pt_ff    <= '0;
         cd_ff    <= '0;
         split_ff <= 1'b0;
         sec_ff   <= '0;
         pc_ff    <= '0;
         tsp_ff   <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         pt_ff    <= pt_in;
         cd_ff    <= cd_in;
         split_ff <= split_in;
         sec_ff   <= sec_in;
         pc_ff    <= pc_in;
         // end of a run restarts the debounce window
         tsp_ff   <= finish ? '0 : tsp_in;
      end
   end

   `TVPC_ASSERT_SAME(a_done_while_busy, clock, reset, step_en && res.run_done, res.busy_res)
   `TVPC_ASSERT_SAME(a_idle_counters_clear, clock, reset, phase_ff == tvpc_pkg::PhIdle,
                     pt_ff == '0 && cd_ff == '0)
   `TVPC_ASSERT_SAME(a_pause_only_split, clock, reset, phase_ff == tvpc_pkg::PhPause, split_ff)
   `TVPC_ASSERT_NEXT(a_done_clears_debounce, clock, reset, step_en && res.run_done,
                     tsp_ff == '0 && phase_ff == tvpc_pkg::PhIdle)

endmodule

// ===== rtl/core/timed_valve_pulse_counter.sv =====
// Timed valve pulse counter. Every req transfer is one millisecond tick carrying the flow-meter
// edge flag and the four button levels; every tick gives exactly one rsp transfer describing
// that tick (valve state, run state, split cycle, wrapping 32-bit pulse count, run end flag).
// A tick goes through an input register, one pass of step logic (one 8x16 multiply for the open
// length and a 25-bit compare) and a result register; one tick is taken every cycle while the
// result side keeps up. Configuration is written through csr_we, csr_index and csr_wdata; the
// user must write it only while no tick is in flight, as the block itself does not enforce this.
// Debounce, tick rate, pause and cycle count act from the next tick on, even in the middle of a
// run, while the open seconds are taken when a run starts.
`include "timed_valve_pulse_counter_defines.svh"

module timed_valve_pulse_counter (
   input  logic                              clock,
   input  logic                              reset,
   tvpc_req_if.sink                          req_chan,
   tvpc_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [tvpc_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [tvpc_pkg::CfgWidth-1:0]     csr_wdata
);

   tvpc_pkg::cfg_type cfg;
   tvpc_pkg::req_type in_ff;
   tvpc_pkg::rsp_type res, out_ff;
   logic              in_valid_ff, out_valid_ff, advance;

   tvpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tvpc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_ff),
      .cfg     (cfg),
      .res     (res)
   );

   // a tick steps when the result register is free or being drained
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_ff.pulse_edge <= req_chan.pulse_edge;
         in_ff.buttons    <= req_chan.buttons;
      end
      if (advance) begin
         out_ff <= res;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.valve_open   = out_ff.valve_open;
   assign rsp_chan.busy_res     = out_ff.busy_res;
   assign rsp_chan.in_pause     = out_ff.in_pause;
   assign rsp_chan.cycle_number = out_ff.cycle_number;
   assign rsp_chan.pulse_total  = out_ff.pulse_total;
   assign rsp_chan.run_done     = out_ff.run_done;

   `TVPC_ASSERT_NEXT(a_step_fills_output, clock, reset, advance, out_valid_ff)
   `TVPC_ASSERT_SAME(a_stall_holds_input, clock, reset, in_valid_ff && !advance,
                     !req_chan.ready)
   `TVPC_ASSERT_NEXT(a_transfer_loads_input, clock, reset,
                     req_chan.valid && req_chan.ready, in_valid_ff)

endmodule
